[rtl/uerc_pkg.sv]
// Package: shared types and constants for the ultrasonic echo range capture block.
package uerc_pkg;

  // Event kinds carried by an input item
  localparam logic [1:0] KIND_COMPARE  = 2'd0;
  localparam logic [1:0] KIND_OVERFLOW = 2'd1;
  localparam logic [1:0] KIND_ECHO     = 2'd2;
  localparam logic [1:0] KIND_READ     = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_MIN_VALID = 2'd0;
  localparam logic [1:0] REG_MAX_VALID = 2'd1;
  localparam logic [1:0] REG_ERR_LIMIT = 2'd2;
  localparam logic [1:0] REG_FALLBACK  = 2'd3;

  // Configuration reset values
  localparam logic [15:0] MIN_VALID_RST = 16'd590;
  localparam logic [15:0] MAX_VALID_RST = 16'd59000;
  localparam logic [7:0]  ERR_LIMIT_RST = 8'd50;
  localparam logic [15:0] FALLBACK_RST  = 16'd65490;

  // Hardware timer width and the period it wraps at, seen modulo 2^16
  localparam int unsigned COUNTER_WIDTH = 16;
  localparam logic [15:0] TIMER_PERIOD  = 16'((64'd1 << COUNTER_WIDTH) - 64'd1);

  // Ranging cycle counter reload
  localparam logic [2:0] CYCLE_RELOAD = 3'd5;

  // Saturation point of the error count
  localparam logic [7:0] ERR_COUNT_MAX = 8'd255;

  // ticks * 256 / 118 == ticks * 128 / 59; reciprocal of 59 scaled by 2^29,
  // exact for every 16-bit tick count. The factor 128 folds into the shift.
  localparam int unsigned    CM_SHIFT = 22;
  localparam logic [23:0]    CM_RECIP = 24'd9099507;

  // Result of one item before the centimetre conversion
  typedef struct packed {
    logic        trigger_level;
    logic [15:0] distance_ticks;
    logic        used_fallback;
    logic        used_previous;
  } res_t;

endpackage

[rtl/uerc_ifs.sv]
// Interfaces: event, result and configuration channels.
interface uerc_evt_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] counter_value;
  logic        echo_level;

  modport source (output valid, kind, counter_value, echo_level, input ready);
  modport sink   (input valid, kind, counter_value, echo_level, output ready);
endinterface

interface uerc_res_if;
  logic        valid;
  logic        ready;
  logic        trigger_level;
  logic [15:0] distance_ticks;
  logic [17:0] distance_cm_q8;
  logic        used_fallback;
  logic        used_previous;

  modport source (output valid, trigger_level, distance_ticks, distance_cm_q8,
                  used_fallback, used_previous, input ready);
  modport sink   (input valid, trigger_level, distance_ticks, distance_cm_q8,
                  used_fallback, used_previous, output ready);
endinterface

interface uerc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/ultrasonic_echo_range_capture.sv]
// Top level: event-driven ultrasonic echo ranger with windowed, filtered reads.
//
// Each accepted item is one timer or pin event: a compare event, an overflow
// event, an echo pin change, or a read request. Every item gives exactly one
// result item carrying the trigger pin level after the event and, for reads,
// the reported pulse length in ticks and in centimetres (Q8, ticks*256/118),
// with flags telling whether the last valid pulse or the fallback value was
// reported. One item is accepted every clock cycle when the result side keeps
// up; each result is registered in the first stage and then in the second
// stage register before the result side sees it. The first stage updates the
// ranging state and picks the reported value, the second runs the single
// reciprocal multiplier that makes the centimetre figure. Ready follows the
// result side's ready back through both stages, so a stalled result holds
// the pipeline while any empty stage still takes an item. The configuration
// port is always ready; write it only while no item is in flight.
module ultrasonic_echo_range_capture (
  input  logic clk,
  input  logic rst,
  uerc_evt_if.sink   evt,
  uerc_res_if.source res,
  uerc_cfg_if.sink   cfg
);
  import uerc_pkg::*;

  // Configuration registers
  logic [15:0] min_valid_ticks;
  logic [15:0] max_valid_ticks;
  logic [7:0]  error_limit;
  logic [15:0] fallback_ticks;

  // Ranging state
  logic        measure_done,     measure_done_next;
  logic [15:0] pulse_ticks,      pulse_ticks_next;
  logic [15:0] echo_start,       echo_start_next;
  logic [15:0] last_valid_ticks, last_valid_ticks_next;
  logic [7:0]  error_count,      error_count_next;
  logic [2:0]  cycle_skip,       cycle_skip_next;
  logic        trigger_state,    trigger_state_next;

  // Pipeline stages
  logic        s1_valid;
  res_t        s1_res, s1_res_next;
  logic        s2_valid;
  res_t        s2_res;
  logic [17:0] s2_cm;

  logic        evt_take;
  logic        s1_adv;
  logic        s2_adv;
  logic [2:0]  periods;
  logic [15:0] elapsed;
  logic        out_of_window;
  logic [39:0] cm_prod;

  // Advance a stage when it is empty or its contents move on
  assign s2_adv    = !s2_valid || res.ready;
  assign s1_adv    = !s1_valid || s2_adv;
  assign evt.ready = s1_adv;
  assign evt_take  = evt.valid && evt.ready;
  assign cfg.ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_valid_ticks <= MIN_VALID_RST;
      max_valid_ticks <= MAX_VALID_RST;
      error_limit     <= ERR_LIMIT_RST;
      fallback_ticks  <= FALLBACK_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_MIN_VALID: min_valid_ticks <= cfg.data;
        REG_MAX_VALID: max_valid_ticks <= cfg.data;
        REG_ERR_LIMIT: error_limit     <= cfg.data[7:0];
        REG_FALLBACK:  fallback_ticks  <= cfg.data;
        default: ;
      endcase
    end
  end

  // Elapsed ticks across whole timer periods, kept modulo 2^16
  assign periods = CYCLE_RELOAD - cycle_skip;
  assign elapsed = evt.counter_value + 16'(19'(periods) * 19'(TIMER_PERIOD)) - echo_start;

  assign out_of_window = (pulse_ticks < min_valid_ticks) || (pulse_ticks > max_valid_ticks);

  // Event handling and read selection
  always_comb begin
    measure_done_next     = measure_done;
    pulse_ticks_next      = pulse_ticks;
    echo_start_next       = echo_start;
    last_valid_ticks_next = last_valid_ticks;
    error_count_next      = error_count;
    cycle_skip_next       = cycle_skip;
    trigger_state_next    = trigger_state;
    s1_res_next           = '0;

    case (evt.kind)
      KIND_COMPARE: begin
        if (cycle_skip == 3'd0) begin
          // Open a new ranging cycle; drop a pulse whose echo never ended
          if (!measure_done) pulse_ticks_next = '0;
          measure_done_next  = 1'b0;
          trigger_state_next = 1'b1;
          cycle_skip_next    = CYCLE_RELOAD;
        end else begin
          cycle_skip_next = cycle_skip - 3'd1;
        end
      end
      KIND_OVERFLOW: begin
        trigger_state_next = 1'b0;
      end
      KIND_ECHO: begin
        // Ignore pin changes once this cycle's echo is measured
        if (!measure_done) begin
          if (evt.echo_level) begin
            echo_start_next = evt.counter_value;
          end else begin
            pulse_ticks_next  = elapsed;
            measure_done_next = 1'b1;
          end
        end
      end
      KIND_READ: begin
        if (out_of_window && (last_valid_ticks != 16'd0)) begin
          if (error_count > error_limit) begin
            s1_res_next.distance_ticks = fallback_ticks;
            s1_res_next.used_fallback  = 1'b1;
          end else begin
            if (error_count != ERR_COUNT_MAX) error_count_next = error_count + 8'd1;
            s1_res_next.distance_ticks = last_valid_ticks;
            s1_res_next.used_previous  = 1'b1;
          end
        end else begin
          error_count_next           = '0;
          last_valid_ticks_next      = pulse_ticks;
          s1_res_next.distance_ticks = pulse_ticks;
        end
      end
      default: ;
    endcase

    s1_res_next.trigger_level = trigger_state_next;
  end

  // State and first stage
  always_ff @(posedge clk) begin
    if (rst) begin
      measure_done     <= 1'b0;
      pulse_ticks      <= '0;
      echo_start       <= '0;
      last_valid_ticks <= '0;
      error_count      <= '0;
      cycle_skip       <= '0;
      trigger_state    <= 1'b0;
      s1_valid         <= 1'b0;
    end else begin
      if (evt_take) begin
        measure_done     <= measure_done_next;
        pulse_ticks      <= pulse_ticks_next;
        echo_start       <= echo_start_next;
        last_valid_ticks <= last_valid_ticks_next;
        error_count      <= error_count_next;
        cycle_skip       <= cycle_skip_next;
        trigger_state    <= trigger_state_next;
      end
      if (s1_adv) s1_valid <= evt_take;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_take) s1_res <= s1_res_next;
  end

  // Centimetre conversion: one reciprocal multiply, then hold in the output stage
  assign cm_prod = 40'(s1_res.distance_ticks) * 40'(CM_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid) begin
      s2_res <= s1_res;
      s2_cm  <= cm_prod[CM_SHIFT +: 18];
    end
  end

  assign res.valid          = s2_valid;
  assign res.trigger_level  = s2_res.trigger_level;
  assign res.distance_ticks = s2_res.distance_ticks;
  assign res.distance_cm_q8 = s2_cm;
  assign res.used_fallback  = s2_res.used_fallback;
  assign res.used_previous  = s2_res.used_previous;

  // Checks
  a_skip_range: assert property (@(posedge clk) disable iff (rst)
    cycle_skip <= CYCLE_RELOAD)
    else $error("cycle counter left its range");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !(res.used_fallback && res.used_previous))
    else $error("fallback and previous reported together");

  a_non_read_zero: assert property (@(posedge clk) disable iff (rst)
    (evt_take && (evt.kind != KIND_READ)) |=>
      (s1_res.distance_ticks == 16'd0 && !s1_res.used_fallback && !s1_res.used_previous))
    else $error("non-read item carries a distance");

  a_cycle_open: assert property (@(posedge clk) disable iff (rst)
    (evt_take && (evt.kind == KIND_COMPARE) && (cycle_skip == 3'd0)) |=>
      (trigger_state && !measure_done && (cycle_skip == CYCLE_RELOAD)))
    else $error("compare event failed to open a ranging cycle");

  a_cm_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && (res.distance_ticks == 16'd0)) |-> (res.distance_cm_q8 == 18'd0))
    else $error("centimetre value without a tick count");

endmodule

[verif/uerc_checker.sv]
// Checker: watches the event, configuration and result channels and scores every result.
`timescale 1ns / 100ps

module uerc_checker (
  input  logic        clk,
  input  logic        rst,
  uerc_evt_if         evt,
  uerc_res_if         res,
  uerc_cfg_if         cfg,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned fallback_reads,
  output int unsigned previous_reads
);
  import uerc_pkg::*;

  typedef struct packed {
    logic        trig;
    logic [15:0] ticks;
    logic [17:0] cm;
    logic        fb;
    logic        prev;
  } range_result_t;

  // Settings as last written
  logic [15:0] min_ticks;
  logic [15:0] max_ticks;
  logic [7:0]  err_limit;
  logic [15:0] fallback;

  // Ranging state
  logic        done;
  logic [15:0] pulse;
  logic [15:0] echo_start;
  logic [15:0] last_valid;
  logic [7:0]  err_count;
  logic [2:0]  skip;
  logic        trig;

  range_result_t range_results_due[$];

  // Advance the ranging state by one event and return the result it gives
  function automatic range_result_t ranging_step(input logic [1:0] kind,
                                                 input logic [15:0] count,
                                                 input logic level);
    range_result_t r;
    logic [63:0]   elapsed;
    logic          outside;
    r = '0;
    case (kind)
      KIND_COMPARE: begin
        if (skip == 3'd0) begin
          if (!done) pulse = '0;
          done = 1'b0;
          trig = 1'b1;
          skip = CYCLE_RELOAD;
        end else begin
          skip = skip - 3'd1;
        end
      end
      KIND_OVERFLOW: trig = 1'b0;
      KIND_ECHO: begin
        if (!done) begin
          if (level) begin
            echo_start = count;
          end else begin
            elapsed = 64'(count)
                    + (64'(CYCLE_RELOAD) - 64'(skip)) * ((64'd1 << COUNTER_WIDTH) - 64'd1)
                    - 64'(echo_start);
            pulse = elapsed[15:0];
            done = 1'b1;
          end
        end
      end
      KIND_READ: begin
        outside = (pulse < min_ticks) || (pulse > max_ticks);
        if (outside && last_valid != '0) begin
          if (err_count > err_limit) begin
            r.ticks = fallback;
            r.fb = 1'b1;
          end else begin
            if (err_count != ERR_COUNT_MAX) err_count = err_count + 8'd1;
            r.ticks = last_valid;
            r.prev = 1'b1;
          end
        end else begin
          err_count = '0;
          last_valid = pulse;
          r.ticks = pulse;
        end
      end
      default: ;
    endcase
    r.trig = trig;
    r.cm = 18'((32'(r.ticks) * 32'd256) / 32'd118);
    return r;
  endfunction

  always @(posedge clk) begin : score
    range_result_t want;
    range_result_t got;
    if (rst) begin
      min_ticks = MIN_VALID_RST;
      max_ticks = MAX_VALID_RST;
      err_limit = ERR_LIMIT_RST;
      fallback = FALLBACK_RST;
      done = 1'b0;
      pulse = '0;
      echo_start = '0;
      last_valid = '0;
      err_count = '0;
      skip = '0;
      trig = 1'b0;
      range_results_due.delete();
      fail_count = 0;
      fallback_reads = 0;
      previous_reads = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_MIN_VALID: min_ticks = cfg.data;
          REG_MAX_VALID: max_ticks = cfg.data;
          REG_ERR_LIMIT: err_limit = cfg.data[7:0];
          REG_FALLBACK:  fallback = cfg.data;
          default: ;
        endcase
      end
      if (evt.valid && evt.ready)
        range_results_due.push_back(ranging_step(evt.kind, evt.counter_value, evt.echo_level));
      if (res.valid && res.ready) begin
        got = '{res.trigger_level, res.distance_ticks, res.distance_cm_q8,
                res.used_fallback, res.used_previous};
        if (range_results_due.size() == 0) begin
          $display("%0t ns: result with none expected: trig=%0d ticks=%0d cm=%0d fb=%0d prev=%0d",
                   $time, got.trig, got.ticks, got.cm, got.fb, got.prev);
          fail_count++;
        end else begin
          want = range_results_due.pop_front();
          if (got !== want) begin
            $display("%0t ns: expected trig=%0d ticks=%0d cm=%0d fb=%0d prev=%0d", $time,
                     want.trig, want.ticks, want.cm, want.fb, want.prev);
            $display("%0t ns:   actual trig=%0d ticks=%0d cm=%0d fb=%0d prev=%0d", $time,
                     got.trig, got.ticks, got.cm, got.fb, got.prev);
            fail_count++;
          end
          if (want.fb) fallback_reads++;
          if (want.prev) previous_reads++;
        end
      end
    end
    pending = range_results_due.size();
  end

endmodule

[verif/testbench.sv]
// Testbench top: clock, reset, event and settings stimulus, and the final verdict.
`timescale 1ns / 100ps

module testbench;
  import uerc_pkg::*;

  // Generous ceiling: every item may wait out a source gap and a result stall
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst;

  uerc_evt_if evt ();
  uerc_res_if res ();
  uerc_cfg_if cfg ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned fallback_reads;
  int unsigned previous_reads;

  // Stimulus bookkeeping: item count, idling odds, and the settings in force
  int unsigned items_sent = 0;
  int unsigned idle_odds = 4;
  bit          calm = 1'b0;
  int unsigned stall_left = 0;
  logic [2:0]  cycle_phase = 3'd0;
  logic [15:0] cur_min = MIN_VALID_RST;
  logic [15:0] cur_max = MAX_VALID_RST;

  ultrasonic_echo_range_capture u_dut (
    .clk (clk),
    .rst (rst),
    .evt (evt),
    .res (res),
    .cfg (cfg)
  );

  uerc_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .evt            (evt),
    .res            (res),
    .cfg            (cfg),
    .fail_count     (fail_count),
    .pending        (pending),
    .fallback_reads (fallback_reads),
    .previous_reads (previous_reads)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side back-pressure: drop ready in short random bursts unless calm
  always @(negedge clk) begin
    if (stall_left == 0 && !calm && $urandom_range(1, idle_odds) == 1)
      stall_left = $urandom_range(1, 3);
    if (stall_left != 0) begin
      res.ready <= 1'b0;
      stall_left--;
    end else begin
      res.ready <= 1'b1;
    end
  end

  // Offer one event item and hold it until the block takes it. Call at a
  // falling edge; returns at the falling edge after acceptance with valid
  // still high, so back-to-back items never lower and raise valid in one step.
  task automatic send_event(input logic [1:0] kind, input logic [15:0] count,
                            input logic level);
    if (!calm && $urandom_range(1, idle_odds) == 1) begin
      evt.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    evt.valid         <= 1'b1;
    evt.kind          <= kind;
    evt.counter_value <= count;
    evt.echo_level    <= level;
    @(posedge clk);
    while (!evt.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    // Track the ranging cycle counter so echo falls can aim at exact widths
    if (kind == KIND_COMPARE)
      cycle_phase = (cycle_phase == 3'd0) ? CYCLE_RELOAD : cycle_phase - 3'd1;
  endtask

  // Drop valid and hold until every expected result has come back
  task automatic wait_idle();
    evt.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Change all four settings with nothing in flight
  task automatic load_settings(input logic [15:0] lo, input logic [15:0] hi,
                               input logic [7:0] limit, input logic [15:0] fb);
    wait_idle();
    write_reg(REG_MIN_VALID, lo);
    write_reg(REG_MAX_VALID, hi);
    write_reg(REG_ERR_LIMIT, 16'(limit));
    write_reg(REG_FALLBACK, fb);
    cfg.valid <= 1'b0;
    cur_min = lo;
    cur_max = hi;
  endtask

  // Pulse widths clustered on the window edges, the field extremes and the inside
  function automatic logic [15:0] pick_target();
    case ($urandom_range(0, 9))
      0: return cur_min;
      1: return cur_max;
      2: return cur_min - 16'd1;
      3: return cur_max + 16'd1;
      4: return 16'd0;
      5: return 16'hFFFF;
      6: return 16'($urandom);
      default: return (cur_min <= cur_max) ? 16'($urandom_range(cur_min, cur_max))
                                           : 16'($urandom);
    endcase
  endfunction

  // One well-formed measurement: compares until a cycle opens, mostly trigger low,
  // echo rise, a few more timer periods, echo fall timed to give exactly the
  // target width, then reads. A broken one leaves the echo unfinished.
  task automatic ranging_cycle(input logic [15:0] target, input int unsigned reads,
                               input bit allow_broken);
    logic [15:0] rise;
    rise = 16'($urandom);
    while (cycle_phase != 3'd0)
      send_event(KIND_COMPARE, 16'($urandom), 1'($urandom));
    send_event(KIND_COMPARE, 16'($urandom), 1'($urandom));
    if ($urandom_range(0, 9) < 7) send_event(KIND_OVERFLOW, 16'($urandom), 1'($urandom));
    send_event(KIND_ECHO, rise, 1'b1);
    repeat ($urandom_range(0, 4)) send_event(KIND_COMPARE, 16'($urandom), 1'($urandom));
    if (!(allow_broken && $urandom_range(0, 9) == 0))
      send_event(KIND_ECHO, rise + target + 16'(CYCLE_RELOAD - cycle_phase), 1'b0);
    // A stray pin change after the fall must leave the stored pulse alone
    if ($urandom_range(0, 4) == 0) send_event(KIND_ECHO, 16'($urandom), 1'($urandom));
    repeat (reads) send_event(KIND_READ, 16'($urandom), 1'($urandom));
  endtask

  // Mostly measurements with random content, the rest raw events of any kind
  task automatic run_phase(input int unsigned quota);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        send_event(2'($urandom_range(0, 3)), 16'($urandom), 1'($urandom));
      end else if (pick < 80) begin
        ranging_cycle(pick_target(), 1, 1'b1);
      end else if (pick < 97) begin
        ranging_cycle(pick_target(), $urandom_range(2, 12), 1'b1);
      end else begin
        // Long run of reads on one pulse: walks the error count past its limit
        ranging_cycle(pick_target(), $urandom_range(40, 70), 1'b1);
      end
    end
  endtask

  initial begin
    logic [15:0] lo;
    logic [15:0] hi;
    rst = 1'b1;
    evt.valid = 1'b0;
    evt.kind = KIND_COMPARE;
    evt.counter_value = '0;
    evt.echo_level = 1'b0;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = REG_MIN_VALID;
    cfg.data = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed opening at the reset settings
    send_event(KIND_READ, 16'hFFFF, 1'b1);        // no history yet: reports zero
    send_event(KIND_OVERFLOW, 16'h0000, 1'b0);
    send_event(KIND_COMPARE, 16'hFFFF, 1'b1);     // opens a ranging cycle
    send_event(KIND_ECHO, 16'hFFFF, 1'b1);
    repeat (2) send_event(KIND_COMPARE, 16'h0000, 1'b0);
    send_event(KIND_ECHO, 16'h0000, 1'b0);        // spans two periods: full-scale width
    send_event(KIND_ECHO, 16'h1234, 1'b1);        // ignored while done is set
    send_event(KIND_ECHO, 16'h4321, 1'b0);
    send_event(KIND_READ, 16'h0000, 1'b0);        // out of window, no valid yet: taken
    send_event(KIND_READ, 16'hFFFF, 1'b1);        // out of window with history
    send_event(KIND_OVERFLOW, 16'hFFFF, 1'b1);
    repeat (4) send_event(KIND_COMPARE, 16'h5A5A, 1'b0);  // reopen with done still set
    send_event(KIND_ECHO, 16'h0000, 1'b1);
    send_event(KIND_ECHO, 16'd1000 + 16'(CYCLE_RELOAD - cycle_phase), 1'b0);
    send_event(KIND_READ, 16'hA5A5, 1'b0);        // in-window pulse clears the count

    idle_odds = 4;
    run_phase(200);

    // Window wide open: nothing is ever out of range
    load_settings(16'd0, 16'hFFFF, 8'd0, 16'd0);
    idle_odds = 3;
    run_phase(140);

    // Inverted window: every read is out of range, fallback after one miss
    load_settings(16'hFFFF, 16'd0, 8'd0, 16'hFFFF);
    idle_odds = 6;
    run_phase(140);

    load_settings(16'd1000, 16'd2000, 8'd3, 16'($urandom));
    idle_odds = 5;
    run_phase(230);

    // Limit just below saturation: the count saturates before the fallback shows
    lo = 16'($urandom_range(100, 30000));
    hi = 16'($urandom_range(lo + 1, 65000));
    load_settings(lo, hi, 8'd254, 16'($urandom));
    idle_odds = 8;
    ranging_cycle(16'($urandom_range(lo, hi)), 1, 1'b0);
    ranging_cycle(hi + 16'd1, 260, 1'b0);
    run_phase(250);

    load_settings(16'($urandom_range(0, 2000)), 16'($urandom_range(2000, 65535)),
                  8'($urandom_range(0, 10)), 16'hFFFF);
    idle_odds = 4;
    run_phase(230);

    // Last stretch at full rate, back on the reset settings
    load_settings(MIN_VALID_RST, MAX_VALID_RST, ERR_LIMIT_RST, FALLBACK_RST);
    calm = 1'b1;
    run_phase(230);

    wait_idle();
    $display("covered %0d event items over seven window settings", items_sent);
    $display("reads answered from the last valid pulse: %0d, from the fallback: %0d",
             previous_reads, fallback_reads);
    if (fail_count == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Watchdog: end the run if the handshakes stop moving
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
    $display("status: fail");
    $finish;
  end

endmodule

[files.f]
rtl/uerc_pkg.sv
rtl/uerc_ifs.sv
rtl/ultrasonic_echo_range_capture.sv
verif/uerc_checker.sv
verif/testbench.sv
